### design/mbod_pkg.sv
// package for the memory bus with oam dma
// holds state, command, control and status types and fixed bus constants; no dependencies
package mbod_pkg;

    // writable half of the address space, 0x8000 to 0xffff
    localparam int MEM_AW = 15;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    localparam int DMA_BYTES = 160;
    localparam int DMA_IW = 8;
    localparam logic [DMA_IW-1:0] DMA_LAST = DMA_IW'(DMA_BYTES - 1);

    localparam logic [15:0] ADDR_JOYP = 16'hFF00;
    localparam logic [15:0] ADDR_DIV = 16'hFF04;
    localparam logic [15:0] ADDR_DMA = 16'hFF46;
    localparam logic [7:0] OAM_PAGE = 8'hFE;
    localparam logic [7:0] JOYP_BTN = 8'hD0;
    localparam logic [7:0] JOYP_DIR = 8'hE0;

    localparam int IN_W = 48;
    localparam int OUT_W = 16;

    typedef enum logic [1:0] {
        CMD_RD_BYTE = 2'd0,
        CMD_WR_BYTE = 2'd1,
        CMD_RD_WORD = 2'd2,
        CMD_WR_WORD = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BYTE0,
        ST_BYTE1,
        ST_DMA_RD,
        ST_DMA_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic byte_acc;
        logic set_hi;
        logic dma_rd;
        logic dma_wr;
        logic cap_lo;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic clr_last;
        logic is_word;
        logic dma_hit;
        logic hi;
        logic dma_last;
        logic out_free;
    } t_stat;

endpackage

### design/mbod_ctrl.sv
// controller state machine for the memory bus with oam dma
// sequences clear, byte accesses and dma copy; uses mbod_pkg
module mbod_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  mbod_pkg::t_stat i_stat,
    output mbod_pkg::t_ctrl o_ctrl
);

    mbod_pkg::t_state r_state;
    mbod_pkg::t_state n_state;
    logic             more_bytes;

    assign more_bytes = !i_stat.hi && i_stat.is_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbod_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbod_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) n_state = mbod_pkg::ST_IDLE;
            end
            mbod_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = mbod_pkg::ST_BYTE0;
            end
            mbod_pkg::ST_BYTE0, mbod_pkg::ST_BYTE1: begin
                if (i_stat.dma_hit) n_state = mbod_pkg::ST_DMA_RD;
                else if (more_bytes) n_state = mbod_pkg::ST_BYTE1;
                else n_state = mbod_pkg::ST_DONE;
            end
            mbod_pkg::ST_DMA_RD: begin
                n_state = mbod_pkg::ST_DMA_WR;
            end
            mbod_pkg::ST_DMA_WR: begin
                if (!i_stat.dma_last) n_state = mbod_pkg::ST_DMA_RD;
                else if (more_bytes) n_state = mbod_pkg::ST_BYTE1;
                else n_state = mbod_pkg::ST_DONE;
            end
            mbod_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = mbod_pkg::ST_IDLE;
            end
            default: n_state = mbod_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            mbod_pkg::ST_CLEAR: begin
                o_ctrl.clr_step = 1'b1;
            end
            mbod_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_ctrl.accept = i_s_tvalid;
            end
            mbod_pkg::ST_BYTE0, mbod_pkg::ST_BYTE1: begin
                o_ctrl.byte_acc = 1'b1;
                o_ctrl.cap_lo = (r_state == mbod_pkg::ST_BYTE1);
                o_ctrl.set_hi = !i_stat.dma_hit && more_bytes;
            end
            mbod_pkg::ST_DMA_RD: begin
                o_ctrl.dma_rd = 1'b1;
            end
            mbod_pkg::ST_DMA_WR: begin
                o_ctrl.dma_wr = 1'b1;
                o_ctrl.set_hi = i_stat.dma_last && more_bytes;
            end
            mbod_pkg::ST_DONE: begin
                o_ctrl.load_out = i_stat.out_free;
            end
            default: o_ctrl = '0;
        endcase
    end

endmodule

### design/mbod_dpath.sv
// datapath for the memory bus with oam dma
// holds the byte memory, transaction registers, dma counter and output register; uses mbod_pkg
module mbod_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mbod_pkg::IN_W-1:0]     i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mbod_pkg::OUT_W-1:0]    o_m_tdata,
    input  mbod_pkg::t_ctrl               i_ctrl,
    output mbod_pkg::t_stat               o_stat
);

    logic [7:0] mem [mbod_pkg::MEM_DEPTH];

    mbod_pkg::t_cmd             r_cmd;
    logic [15:0]                r_addr;
    logic [15:0]                r_wdata;
    logic [7:0]                 r_joy;
    logic                       r_hi;
    logic [mbod_pkg::MEM_AW-1:0] r_clr;
    logic [7:0]                 r_page;
    logic [mbod_pkg::DMA_IW-1:0] r_dcnt;
    logic [7:0]                 r_rdata;
    logic                       r_rd_hi;
    logic [7:0]                 r_res_lo;
    logic                       r_out_valid;
    logic [15:0]                r_out_data;

    logic                       is_write;
    logic [15:0]                cur_addr;
    logic [7:0]                 cur_wd;
    logic                       byte_we;
    logic [7:0]                 byte_wd;
    logic [7:0]                 rdata_eff;
    logic [15:0]                dma_src;
    logic [15:0]                dma_dst;
    logic [mbod_pkg::MEM_AW-1:0] mem_addr;
    logic                       mem_we;
    logic                       mem_re;
    logic [7:0]                 mem_wd;
    logic                       mem_hi;

    assign is_write = (r_cmd == mbod_pkg::CMD_WR_BYTE) || (r_cmd == mbod_pkg::CMD_WR_WORD);
    assign cur_addr = r_addr + {15'd0, r_hi};
    assign cur_wd = r_hi ? r_wdata[15:8] : r_wdata[7:0];
    assign rdata_eff = r_rd_hi ? r_rdata : 8'h00;
    assign dma_src = {r_page, r_dcnt};
    assign dma_dst = {mbod_pkg::OAM_PAGE, r_dcnt};

    // byte write rules for addresses from 0x8000 up, with joypad and divider cases in the i/o page
    always_comb begin
        byte_we = 1'b0;
        byte_wd = cur_wd;
        if (is_write && cur_addr[15]) begin
            if (cur_addr == mbod_pkg::ADDR_JOYP) begin
                if (cur_wd[4]) begin
                    byte_we = 1'b1;
                    byte_wd = mbod_pkg::JOYP_BTN | {4'h0, r_joy[3:0]};
                end else if (cur_wd[5]) begin
                    byte_we = 1'b1;
                    byte_wd = mbod_pkg::JOYP_DIR | {4'h0, r_joy[7:4]};
                end
            end else if (cur_addr == mbod_pkg::ADDR_DIV) begin
                byte_we = 1'b1;
                byte_wd = 8'h00;
            end else begin
                byte_we = 1'b1;
            end
        end
    end

    always_comb begin
        mem_addr = r_clr;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wd = 8'h00;
        mem_hi = 1'b0;
        if (i_ctrl.clr_step) begin
            mem_we = 1'b1;
        end else if (i_ctrl.byte_acc) begin
            mem_addr = cur_addr[mbod_pkg::MEM_AW-1:0];
            mem_we = byte_we;
            mem_wd = byte_wd;
            mem_re = !is_write;
            mem_hi = cur_addr[15];
        end else if (i_ctrl.dma_rd) begin
            mem_addr = dma_src[mbod_pkg::MEM_AW-1:0];
            mem_re = 1'b1;
            mem_hi = dma_src[15];
        end else if (i_ctrl.dma_wr) begin
            mem_addr = dma_dst[mbod_pkg::MEM_AW-1:0];
            mem_we = 1'b1;
            mem_wd = rdata_eff;
        end
    end

    // bytes below 0x8000 are never written and read as zero
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
            r_rd_hi <= mem_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd <= mbod_pkg::t_cmd'(i_s_tdata[1:0]);
            r_addr <= i_s_tdata[17:2];
            r_wdata <= i_s_tdata[33:18];
            r_joy <= i_s_tdata[41:34];
        end
        if (i_ctrl.byte_acc && o_stat.dma_hit) begin
            r_page <= cur_wd;
            r_dcnt <= '0;
        end else if (i_ctrl.dma_wr) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_ctrl.cap_lo) r_res_lo <= rdata_eff;
        if (i_ctrl.load_out) begin
            case (r_cmd)
                mbod_pkg::CMD_RD_BYTE: r_out_data <= {8'h00, rdata_eff};
                mbod_pkg::CMD_RD_WORD: r_out_data <= {rdata_eff, r_res_lo};
                default:               r_out_data <= 16'h0000;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_hi <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.clr_step) r_clr <= r_clr + 1'b1;
            if (i_ctrl.accept) r_hi <= 1'b0;
            else if (i_ctrl.set_hi) r_hi <= 1'b1;
            if (i_ctrl.load_out) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    assign o_stat.clr_last = &r_clr;
    assign o_stat.is_word = (r_cmd == mbod_pkg::CMD_RD_WORD) || (r_cmd == mbod_pkg::CMD_WR_WORD);
    assign o_stat.dma_hit = is_write && (cur_addr == mbod_pkg::ADDR_DMA);
    assign o_stat.hi = r_hi;
    assign o_stat.dma_last = (r_dcnt == mbod_pkg::DMA_LAST);
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out_data;

endmodule

### design/memory_mapped_bus_with_oam_dma_unit.sv
// top level of the memory bus with oam dma
// joins mbod_ctrl and mbod_dpath; uses mbod_pkg
//
// channel   direction  ports                               contents
// s         in         i_s_tvalid o_s_tready i_s_tdata     command, address, write_data, joypad_state
// m         out        o_m_tvalid i_m_tready o_m_tdata     read_data
//
// a byte command steps through ST_BYTE0 and ST_DONE, a word command through ST_BYTE0, ST_BYTE1 and ST_DONE
// a write that hits 0xff46 starts an oam dma of 160 bytes, each read and then written through the single memory port
// after reset a clearing pass writes zero to all 32768 bytes of the upper half memory before the first transaction
// one transaction in flight; a finished result waits in the output register while the next is accepted
module memory_mapped_bus_with_oam_dma_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // command[1:0] address[17:2] write_data[33:18] joypad_state[41:34]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // read_data[15:0]
);

    mbod_pkg::t_ctrl ctrl;
    mbod_pkg::t_stat stat;

    mbod_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    mbod_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_ctrl     (ctrl),
        .o_stat     (stat)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench for memory_mapped_bus_with_oam_dma_unit: directed table, then random bus traffic
// predicts every read against a shadow of the 64 KiB memory; depends on mbod_pkg and the rtl
module tb_top;

    localparam int RAND_ITEMS = 1630;
    localparam int CALM_ITEMS = 200;
    localparam int LIMIT = 3_000_000;
    localparam logic [15:0] OAM_BASE = 16'hFE00;
    localparam logic [15:0] ROM_LIMIT = 16'h8000;
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_TOP = 16'hFFFF;

    typedef struct {
        mbod_pkg::t_cmd cmd;
        logic [15:0]    addr;
        logic [15:0]    wd;
        logic [7:0]     joy;
        bit             typed;
        logic [15:0]    val;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_valid;
    logic [47:0] s_data;
    logic        m_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;

    logic [7:0]  shadow_mem [0:65535];
    logic [15:0] read_q [$];
    t_dir_row    dir_q [$];
    bit          calm = 1'b0;
    int          errors = 0;
    int          results_seen = 0;
    int          cycles = 0;
    int          n_rd = 0;
    int          n_wr = 0;
    int          n_dma = 0;

    always #4 i_clk = ~i_clk;

    memory_mapped_bus_with_oam_dma_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata)
    );

    task report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at result %0d", what, got, want, results_seen);
    endtask

    task shadow_write(input logic [15:0] addr, input logic [7:0] d8, input logic [7:0] joy);
        logic [15:0] src;
        logic [15:0] dst;
        if (addr < ROM_LIMIT) begin
            return;
        end
        if (addr == mbod_pkg::ADDR_JOYP) begin
            if (d8[4])
                shadow_mem[addr] = mbod_pkg::JOYP_BTN | {4'h0, joy[3:0]};
            else if (d8[5])
                shadow_mem[addr] = mbod_pkg::JOYP_DIR | {4'h0, joy[7:4]};
        end else if (addr == mbod_pkg::ADDR_DIV) begin
            shadow_mem[addr] = 8'h00;
        end else if (addr == mbod_pkg::ADDR_DMA) begin
            shadow_mem[addr] = d8;
            n_dma++;
            src = {d8, 8'h00};
            dst = OAM_BASE;
            // ascending copy, each byte read and then written in the order of the dma counter
            for (int i = 0; i < mbod_pkg::DMA_BYTES; i++) begin
                shadow_mem[dst] = shadow_mem[src];
                src = src + 16'd1;
                dst = dst + 16'd1;
            end
        end else begin
            shadow_mem[addr] = d8;
        end
    endtask

    task predict_bus(input mbod_pkg::t_cmd cmd, input logic [15:0] addr, input logic [15:0] wd,
                     input logic [7:0] joy, output logic [15:0] rd);
        logic [15:0] next_a;
        next_a = addr + 16'd1;
        rd = 16'h0000;
        case (cmd)
            mbod_pkg::CMD_RD_BYTE: begin
                rd = {8'h00, shadow_mem[addr]};
                n_rd++;
            end
            mbod_pkg::CMD_WR_BYTE: begin
                shadow_write(addr, wd[7:0], joy);
                n_wr++;
            end
            mbod_pkg::CMD_RD_WORD: begin
                rd = {shadow_mem[next_a], shadow_mem[addr]};
                n_rd++;
            end
            default: begin
                shadow_write(addr, wd[7:0], joy);
                shadow_write(next_a, wd[15:8], joy);
                n_wr++;
            end
        endcase
    endtask

    task add_row(input mbod_pkg::t_cmd cmd, input logic [15:0] addr, input logic [15:0] wd,
                 input logic [7:0] joy, input bit typed, input logic [15:0] val);
        t_dir_row r;
        r.cmd = cmd;
        r.addr = addr;
        r.wd = wd;
        r.joy = joy;
        r.typed = typed;
        r.val = val;
        dir_q.push_back(r);
    endtask

    // entered and left at a falling edge
    task send_item(input mbod_pkg::t_cmd cmd, input logic [15:0] addr, input logic [15:0] wd,
                   input logic [7:0] joy, input bit typed, input logic [15:0] val);
        logic [15:0] pred;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {6'b0, joy, wd, addr, cmd};
        do
            @(posedge i_clk);
        while (!(s_valid && o_s_tready));
        predict_bus(cmd, addr, wd, joy, pred);
        read_q.push_back(typed ? val : pred);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [15:0] want;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            if (read_q.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_tdata, 16'h0000);
            end else begin
                want = read_q.pop_front();
                if (o_m_tdata !== want)
                    report_mismatch("read_data", o_m_tdata, want);
            end
            results_seen++;
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    initial begin
        mbod_pkg::t_cmd cmd;
        logic [15:0]    addr;
        logic [15:0]    wd;
        logic [7:0]     joy;
        logic [7:0]     page;
        int             sel;
        s_valid = 1'b0;
        s_data = '0;
        i_rst_n = 1'b0;
        for (int a = 0; a < 65536; a++)
            shadow_mem[a] = 8'h00;

        // after reset, rom writes, upper data bits, top wrap
        add_row(mbod_pkg::CMD_RD_BYTE, 16'h0000, 16'h0000, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_WORD, ADDR_TOP, 16'h0000, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_WR_BYTE, 16'h1234, 16'h00AB, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_WR_BYTE, ROM_LIMIT, 16'hFF55, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_BYTE, ROM_LIMIT, 16'h0000, 8'h00, 1, 16'h0055);
        add_row(mbod_pkg::CMD_WR_WORD, ADDR_TOP, 16'hA5C3, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_WORD, ADDR_TOP, 16'hFFFF, 8'h00, 1, 16'h00C3);
        // joypad select
        add_row(mbod_pkg::CMD_WR_BYTE, mbod_pkg::ADDR_JOYP, 16'h0010, 8'h3A, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_BYTE, mbod_pkg::ADDR_JOYP, 16'h0000, 8'h00, 1, 16'h00DA);
        add_row(mbod_pkg::CMD_WR_BYTE, mbod_pkg::ADDR_JOYP, 16'h0020, 8'h3A, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_BYTE, mbod_pkg::ADDR_JOYP, 16'h0000, 8'h00, 1, 16'h00E3);
        add_row(mbod_pkg::CMD_WR_BYTE, mbod_pkg::ADDR_JOYP, 16'h00CF, 8'hFF, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_BYTE, mbod_pkg::ADDR_JOYP, 16'h0000, 8'hFF, 1, 16'h00E3);
        // divider clear and lcd registers
        add_row(mbod_pkg::CMD_WR_WORD, mbod_pkg::ADDR_DIV - 16'd1, 16'h9988, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_WORD, mbod_pkg::ADDR_DIV - 16'd1, 16'h0000, 8'h00, 1, 16'h0088);
        add_row(mbod_pkg::CMD_WR_WORD, ADDR_LCDC, 16'h8591, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_WORD, ADDR_LCDC, 16'h0000, 8'h00, 0, 16'h0000);
        add_row(mbod_pkg::CMD_RD_BYTE, ADDR_STAT, 16'h0000, 8'h00, 1, 16'h0085);
        // oam dma, plain and onto itself
        add_row(mbod_pkg::CMD_WR_BYTE, 16'hC000, 16'h0012, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_WR_BYTE, 16'hC09F, 16'h0034, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_WR_BYTE, mbod_pkg::ADDR_DMA, 16'h00C0, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_WORD, OAM_BASE + 16'h009E, 16'h0000, 8'h00, 0, 16'h0000);
        add_row(mbod_pkg::CMD_WR_BYTE, mbod_pkg::ADDR_DMA, 16'h00FE, 8'h00, 1, 16'h0000);
        add_row(mbod_pkg::CMD_RD_BYTE, OAM_BASE, 16'h0000, 8'h00, 0, 16'h0000);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_q[k])
            send_item(dir_q[k].cmd, dir_q[k].addr, dir_q[k].wd, dir_q[k].joy,
                      dir_q[k].typed, dir_q[k].val);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= RAND_ITEMS - CALM_ITEMS);
            sel = $urandom_range(0, 99);
            joy = 8'($urandom_range(0, 255));
            wd = 16'($urandom_range(0, 65535));
            if (sel < 4) begin
                cmd = mbod_pkg::CMD_WR_BYTE;
                addr = mbod_pkg::ADDR_DMA;
                case ($urandom_range(0, 5))
                    0: page = 8'hC0;
                    1: page = 8'hC1;
                    2: page = mbod_pkg::OAM_PAGE;
                    3: page = 8'hFF;
                    4: page = 8'h00;
                    default: page = 8'($urandom_range(0, 255));
                endcase
                wd = {wd[15:8], page};
            end else begin
                cmd = mbod_pkg::t_cmd'($urandom_range(0, 3));
                if (sel < 34)
                    addr = OAM_BASE + 16'($urandom_range(0, 191));
                else if (sel < 52)
                    addr = mbod_pkg::ADDR_JOYP + 16'($urandom_range(0, 79));
                else if (sel < 62) begin
                    case ($urandom_range(0, 7))
                        0: addr = mbod_pkg::ADDR_JOYP;
                        1: addr = mbod_pkg::ADDR_DIV;
                        2: addr = ADDR_LCDC;
                        3: addr = ADDR_STAT;
                        4: addr = ADDR_TOP;
                        5: addr = ROM_LIMIT - 16'd1;
                        6: addr = ROM_LIMIT;
                        default: addr = 16'h0000;
                    endcase
                end else if (sel < 77)
                    addr = 16'hC000 + 16'($urandom_range(0, 511));
                else
                    addr = 16'($urandom_range(0, 65535));
            end
            send_item(cmd, addr, wd, joy, 0, 16'h0000);
        end
        s_valid <= 1'b0;

        while (read_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("covered %0d reads and %0d writes, %0d of them oam dma triggers",
                 n_rd, n_wr, n_dma);
        $display("%0d results compared, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
